[rtl/pdb_pkg.sv]
// Shared constants, types and arctangent table for the point distance and bearing block.
`timescale 1ns / 1ps

package pdb_pkg;

   localparam int COORD_WIDTH   = 16;
   localparam int CORDIC_STAGES = 16;
   localparam int ATAN_ENTRIES  = 24;
   localparam int NUM_ITER      = (CORDIC_STAGES < ATAN_ENTRIES) ? CORDIC_STAGES : ATAN_ENTRIES;

   localparam int GUARD_BITS = 8;
   localparam int DIFF_W     = COORD_WIDTH + 1;
   // room for guard bits, the CORDIC gain and the diagonal length
   localparam int DATA_W     = DIFF_W + GUARD_BITS + 3;
   localparam int ANGLE_W    = 32;
   localparam int BEARING_W  = 16;
   localparam int SPAN_W     = COORD_WIDTH + 1;

   localparam int GAIN_W    = 20;
   localparam int GAIN_FRAC = 20;
   localparam logic [GAIN_W-1:0] GAIN_INV = 20'd636751;
   localparam int PROD_W    = DATA_W - 1 + GAIN_W;
   localparam int SPAN_SHIFT = GAIN_FRAC + GUARD_BITS;
   localparam int QUOT_W    = PROD_W + 1 - SPAN_SHIFT;

   // pre-rotation stage, one stage per iteration, multiply stage, output stage
   localparam int NUM_STAGES  = NUM_ITER + 3;
   localparam int IN_FLIGHT_W = $clog2(NUM_STAGES + 1);

   localparam logic [ANGLE_W-1:0] ANGLE_PLUS_HALF_PI  = 32'h4000_0000;
   localparam logic [ANGLE_W-1:0] ANGLE_MINUS_HALF_PI = 32'hC000_0000;
   localparam logic [ANGLE_W-1:0] ANGLE_ROUND         = 32'h0000_8000;

   typedef logic signed [COORD_WIDTH-1:0] coord_type;
   typedef logic signed [DATA_W-1:0]      data_type;
   typedef logic [ANGLE_W-1:0]            angle_type;

   // atan(2^-i) scaled so that pi = 2^31
   function automatic angle_type atan_entry(input logic [4:0] idx);
      angle_type val;
      case (idx)
         5'd0:    val = 32'h20000000;
         5'd1:    val = 32'h12E4051E;
         5'd2:    val = 32'h09FB385B;
         5'd3:    val = 32'h051111D4;
         5'd4:    val = 32'h028B0D43;
         5'd5:    val = 32'h0145D7E1;
         5'd6:    val = 32'h00A2F61E;
         5'd7:    val = 32'h00517C55;
         5'd8:    val = 32'h0028BE53;
         5'd9:    val = 32'h00145F2F;
         5'd10:   val = 32'h000A2F98;
         5'd11:   val = 32'h000517CC;
         5'd12:   val = 32'h00028BE6;
         5'd13:   val = 32'h000145F3;
         5'd14:   val = 32'h0000A2FA;
         5'd15:   val = 32'h0000517D;
         5'd16:   val = 32'h000028BE;
         5'd17:   val = 32'h0000145F;
         5'd18:   val = 32'h00000A30;
         5'd19:   val = 32'h00000518;
         5'd20:   val = 32'h0000028C;
         5'd21:   val = 32'h00000146;
         5'd22:   val = 32'h000000A3;
         5'd23:   val = 32'h00000051;
         default: val = '0;
      endcase
      return val;
   endfunction

endpackage

[rtl/pdb_if.sv]
// Request and response channel interfaces for the point distance and bearing block.
`timescale 1ns / 1ps

interface pdb_req_if;
   logic                valid;
   logic                ready;
   pdb_pkg::coord_type  first_x;
   pdb_pkg::coord_type  first_y;
   pdb_pkg::coord_type  second_x;
   pdb_pkg::coord_type  second_y;

   modport source (output valid, first_x, first_y, second_x, second_y, input ready);
   modport sink   (input valid, first_x, first_y, second_x, second_y, output ready);
   modport monitor (input valid, ready, first_x, first_y, second_x, second_y);
endinterface

interface pdb_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [pdb_pkg::SPAN_W-1:0]        span;
   logic signed [pdb_pkg::BEARING_W-1:0] bearing;

   modport source (output valid, span, bearing, input ready);
   modport sink   (input valid, span, bearing, output ready);
   modport monitor (input valid, ready, span, bearing);
endinterface

[rtl/point_distance_and_bearing_top.sv]
// Throughput: one request per cycle unless stalled; each iteration has its own register stage.
// A stalled response holds the last stage and every full stage behind it; bubbles still fill.
// Reset (synchronous, active high) clears every stage valid bit; data registers are not reset.
// Top level: unrolled CORDIC vectoring pipeline for distance and bearing.
`timescale 1ns / 1ps

module point_distance_and_bearing_top (
   input  logic        clock,
   input  logic        reset,
   pdb_req_if.sink     req_ch,
   pdb_rsp_if.source   rsp_ch
);

   localparam int NI  = pdb_pkg::NUM_ITER;
   localparam int NS  = pdb_pkg::NUM_STAGES;
   localparam int MUL = NI + 1;
   localparam int OUT = NI + 2;

   logic [NS-1:0] vld_ff;
   logic [NS-1:0] ready;

   // CORDIC stages: index 0 is the pre-rotation, k is after iteration k-1
   pdb_pkg::data_type  x_ff    [0:NI];
   pdb_pkg::data_type  y_ff    [0:NI];
   pdb_pkg::angle_type z_ff    [0:NI];
   logic               zero_ff [0:NI];
   pdb_pkg::data_type  x_in    [0:NI];
   pdb_pkg::data_type  y_in    [0:NI];
   pdb_pkg::angle_type z_in    [0:NI];

   logic [pdb_pkg::PROD_W-1:0]  prod_ff, prod_in;
   pdb_pkg::angle_type          mz_ff;
   logic                        mzero_ff;

   logic [pdb_pkg::SPAN_W-1:0]           span_ff, span_in;
   logic signed [pdb_pkg::BEARING_W-1:0] bearing_ff, bearing_in;

   // ready ripples back: a stage takes data when empty or when it moves on
   always_comb begin
      ready[NS-1] = !vld_ff[NS-1] || rsp_ch.ready;
      for (int s = NS - 2; s >= 0; s--) begin
         ready[s] = !vld_ff[s] || ready[s+1];
      end
   end

   assign req_ch.ready = ready[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         if (ready[0]) vld_ff[0] <= req_ch.valid;
         for (int s = 1; s < NS; s++) begin
            if (ready[s]) vld_ff[s] <= vld_ff[s-1];
         end
      end
   end

   // pre-rotation into the right half plane
   logic signed [pdb_pkg::DIFF_W-1:0] dx, dy;
   pdb_pkg::data_type                 xs0, ys0;
   logic                              zero_in;

   assign dx = pdb_pkg::DIFF_W'(req_ch.second_x) - pdb_pkg::DIFF_W'(req_ch.first_x);
   assign dy = pdb_pkg::DIFF_W'(req_ch.first_y) - pdb_pkg::DIFF_W'(req_ch.second_y);
   assign xs0 = pdb_pkg::data_type'(pdb_pkg::DATA_W'(dx) <<< pdb_pkg::GUARD_BITS);
   assign ys0 = pdb_pkg::data_type'(pdb_pkg::DATA_W'(dy) <<< pdb_pkg::GUARD_BITS);
   assign zero_in = (dx == '0) && (dy == '0);

   always_comb begin
      if (xs0[pdb_pkg::DATA_W-1] && !ys0[pdb_pkg::DATA_W-1]) begin
         x_in[0] = ys0;
         y_in[0] = -xs0;
         z_in[0] = pdb_pkg::ANGLE_PLUS_HALF_PI;
      end else if (xs0[pdb_pkg::DATA_W-1]) begin
         x_in[0] = -ys0;
         y_in[0] = xs0;
         z_in[0] = pdb_pkg::ANGLE_MINUS_HALF_PI;
      end else begin
         x_in[0] = xs0;
         y_in[0] = ys0;
         z_in[0] = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (ready[0] && req_ch.valid) begin
         x_ff[0]    <= x_in[0];
         y_ff[0]    <= y_in[0];
         z_ff[0]    <= z_in[0];
         zero_ff[0] <= zero_in;
      end
   end

   // one micro-rotation per stage
   for (genvar k = 1; k <= NI; k++) begin : g_iter
      localparam int SH = k - 1;
      pdb_pkg::data_type  xsh, ysh;
      pdb_pkg::angle_type atan_k;

      assign xsh    = x_ff[k-1] >>> SH;
      assign ysh    = y_ff[k-1] >>> SH;
      assign atan_k = pdb_pkg::atan_entry(5'(SH));

      assign x_in[k] = !y_ff[k-1][pdb_pkg::DATA_W-1] ? x_ff[k-1] + ysh : x_ff[k-1] - ysh;
      assign y_in[k] = !y_ff[k-1][pdb_pkg::DATA_W-1] ? y_ff[k-1] - xsh : y_ff[k-1] + xsh;
      assign z_in[k] = !y_ff[k-1][pdb_pkg::DATA_W-1] ? z_ff[k-1] + atan_k
                                                     : z_ff[k-1] - atan_k;

      always_ff @(posedge clock) begin
         if (ready[k] && vld_ff[k-1]) begin
            x_ff[k]    <= x_in[k];
            y_ff[k]    <= y_in[k];
            z_ff[k]    <= z_in[k];
            zero_ff[k] <= zero_ff[k-1];
         end
      end
   end

   // gain correction multiply; negative x clamps to zero
   logic [pdb_pkg::DATA_W-2:0] x_pos;

   assign x_pos   = x_ff[NI][pdb_pkg::DATA_W-1] ? '0 : x_ff[NI][pdb_pkg::DATA_W-2:0];
   assign prod_in = pdb_pkg::PROD_W'(x_pos) * pdb_pkg::PROD_W'(pdb_pkg::GAIN_INV);

   always_ff @(posedge clock) begin
      if (ready[MUL] && vld_ff[MUL-1]) begin
         prod_ff  <= prod_in;
         mz_ff    <= z_ff[NI];
         mzero_ff <= zero_ff[NI];
      end
   end

   // round, saturate, and round the angle to 16 bits
   logic [pdb_pkg::PROD_W:0]   prod_rnd;
   logic [pdb_pkg::QUOT_W-1:0] span_q;
   pdb_pkg::angle_type         z_rnd;

   assign prod_rnd = (pdb_pkg::PROD_W+1)'(prod_ff)
                   + ((pdb_pkg::PROD_W+1)'(1) << (pdb_pkg::SPAN_SHIFT - 1));
   assign span_q   = prod_rnd[pdb_pkg::PROD_W:pdb_pkg::SPAN_SHIFT];
   assign z_rnd    = mz_ff + pdb_pkg::ANGLE_ROUND;

   always_comb begin
      if (span_q > {{(pdb_pkg::QUOT_W - pdb_pkg::SPAN_W){1'b0}}, {pdb_pkg::SPAN_W{1'b1}}}) begin
         span_in = '1;
      end else begin
         span_in = span_q[pdb_pkg::SPAN_W-1:0];
      end
      if (mzero_ff) begin
         bearing_in = '0;
      end else begin
         bearing_in = z_rnd[pdb_pkg::ANGLE_W-1 -: pdb_pkg::BEARING_W];
      end
   end

   always_ff @(posedge clock) begin
      if (ready[OUT] && vld_ff[OUT-1]) begin
         span_ff    <= span_in;
         bearing_ff <= bearing_in;
      end
   end

   assign rsp_ch.valid   = vld_ff[OUT];
   assign rsp_ch.span    = span_ff;
   assign rsp_ch.bearing = bearing_ff;

endmodule

[rtl/pdb_checker.sv]
// Port-level assertions for the point distance and bearing block, bound to the top level.
`timescale 1ns / 1ps

module pdb_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [pdb_pkg::SPAN_W-1:0]    rsp_span,
   input logic [pdb_pkg::BEARING_W-1:0] rsp_bearing
);

   logic [pdb_pkg::IN_FLIGHT_W-1:0] in_flight_ff, in_flight_in;
   logic                            req_take, rsp_take;

   assign req_take = req_valid && req_ready;
   assign rsp_take = rsp_valid && rsp_ready;

   always_comb begin
      in_flight_in = in_flight_ff;
      if (req_take && !rsp_take) in_flight_in = in_flight_ff + 1'b1;
      if (!req_take && rsp_take) in_flight_in = in_flight_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_flight_ff <= '0;
      end else begin
         in_flight_ff <= in_flight_in;
      end
   end

   // stalled response holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=>
         rsp_valid && $stable(rsp_span) && $stable(rsp_bearing))
      else $error("response changed while stalled");

   // no response without a request in flight
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> in_flight_ff != '0)
      else $error("response with no request outstanding");

   // never more requests held than there are stages
   assert property (@(posedge clock) disable iff (reset)
      in_flight_ff <= pdb_pkg::IN_FLIGHT_W'(pdb_pkg::NUM_STAGES))
      else $error("more requests in flight than stages");

   // an empty output stage lets the whole pipe advance
   assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("request stalled with output stage empty");

endmodule

bind point_distance_and_bearing_top pdb_checker u_pdb_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_ch.valid),
   .req_ready   (req_ch.ready),
   .rsp_valid   (rsp_ch.valid),
   .rsp_ready   (rsp_ch.ready),
   .rsp_span    (rsp_ch.span),
   .rsp_bearing (rsp_ch.bearing)
);

[test/point_distance_and_bearing_top_test.sv]
// Self-checking testbench for the point distance and bearing pipeline.
`timescale 1ns / 1ps

module point_distance_and_bearing_top_test;

   localparam int ROTATIONS     = (pdb_pkg::CORDIC_STAGES < 24) ? pdb_pkg::CORDIC_STAGES : 24;
   localparam int RANDOM_PAIRS  = 1440;
   localparam int STALL_LIMIT   = 2000;
   localparam int RSP_HOLD_AT   = 380;
   localparam int RSP_HOLD_LEN  = 150;
   localparam logic [31:0] PHASE_PLUS_QUARTER  = 32'h4000_0000;
   localparam logic [31:0] PHASE_MINUS_QUARTER = 32'hC000_0000;
   localparam longint unsigned INV_GAIN = 64'd636751;
   localparam longint unsigned SPAN_MAX = (64'd1 << (pdb_pkg::COORD_WIDTH + 1)) - 1;

   typedef struct packed {
      pdb_pkg::coord_type  first_x;
      pdb_pkg::coord_type  first_y;
      pdb_pkg::coord_type  second_x;
      pdb_pkg::coord_type  second_y;
      logic [3:0]          idle_before;
      logic                wait_drain;
   } point_pair_type;

   typedef struct packed {
      pdb_pkg::coord_type                     first_x;
      pdb_pkg::coord_type                     first_y;
      pdb_pkg::coord_type                     second_x;
      pdb_pkg::coord_type                     second_y;
      logic [pdb_pkg::SPAN_W-1:0]             span;
      logic signed [pdb_pkg::BEARING_W-1:0]   bearing;
   } polar_type;

   logic clock;
   logic reset;

   pdb_req_if req_ch ();
   pdb_rsp_if rsp_ch ();

   point_distance_and_bearing_top dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   point_pair_type pair_queue[$];
   polar_type      polar_expect[$];
   int unsigned fault_count;
   int unsigned pairs_made;
   logic        req_taken;
   logic        rsp_taken;

   // driver state
   point_pair_type cur_pair;
   logic        have_pair;
   int          idle_left;

   // receiver state
   int unsigned rsp_seen;
   int          wait_left;
   int          hold_left;

   int unsigned quiet_cycles;

   function automatic logic [31:0] arctan_step(input int idx);
      logic [31:0] val;
      case (idx)
         0:       val = 32'h20000000;
         1:       val = 32'h12E4051E;
         2:       val = 32'h09FB385B;
         3:       val = 32'h051111D4;
         4:       val = 32'h028B0D43;
         5:       val = 32'h0145D7E1;
         6:       val = 32'h00A2F61E;
         7:       val = 32'h00517C55;
         8:       val = 32'h0028BE53;
         9:       val = 32'h00145F2F;
         10:      val = 32'h000A2F98;
         11:      val = 32'h000517CC;
         12:      val = 32'h00028BE6;
         13:      val = 32'h000145F3;
         14:      val = 32'h0000A2FA;
         15:      val = 32'h0000517D;
         16:      val = 32'h000028BE;
         17:      val = 32'h0000145F;
         18:      val = 32'h00000A30;
         19:      val = 32'h00000518;
         20:      val = 32'h0000028C;
         21:      val = 32'h00000146;
         22:      val = 32'h000000A3;
         default: val = 32'h00000051;
      endcase
      return val;
   endfunction

   // vectoring CORDIC on (second_x - first_x, first_y - second_y)
   function automatic polar_type predict_polar(input pdb_pkg::coord_type fx,
                                               input pdb_pkg::coord_type fy,
                                               input pdb_pkg::coord_type sx,
                                               input pdb_pkg::coord_type sy);
      polar_type        r;
      longint           vx, vy, hx, hy, t;
      logic [31:0]      phase;
      longint unsigned  scaled, span_est;
      r = '0;
      r.first_x  = fx;
      r.first_y  = fy;
      r.second_x = sx;
      r.second_y = sy;
      vx = longint'(sx) - longint'(fx);
      vy = longint'(fy) - longint'(sy);
      if (vx == 0 && vy == 0)
         return r;
      vx = vx * 256;
      vy = vy * 256;
      phase = '0;
      if (vx < 0) begin
         t = vx;
         if (vy >= 0) begin
            vx = vy;
            vy = -t;
            phase = PHASE_PLUS_QUARTER;
         end else begin
            vx = -vy;
            vy = t;
            phase = PHASE_MINUS_QUARTER;
         end
      end
      for (int i = 0; i < ROTATIONS; i++) begin
         hx = vx >>> i;
         hy = vy >>> i;
         if (vy >= 0) begin
            vx = vx + hy;
            vy = vy - hx;
            phase = phase + arctan_step(i);
         end else begin
            vx = vx - hy;
            vy = vy + hx;
            phase = phase - arctan_step(i);
         end
      end
      if (vx < 0)
         vx = 0;
      scaled = longint'(vx) * INV_GAIN;
      span_est = (scaled + (64'd1 << 27)) >> 28;
      if (span_est > SPAN_MAX)
         span_est = SPAN_MAX;
      r.span = span_est[pdb_pkg::SPAN_W-1:0];
      phase = phase + 32'h0000_8000;
      r.bearing = phase[31:16];
      return r;
   endfunction

   task automatic report_mismatch(input string what);
      fault_count++;
      $display("%0t MISMATCH: %s", $realtime, what);
   endtask

   task automatic push_pair(input int fx, input int fy, input int sx, input int sy,
                            input bit drain);
      point_pair_type p;
      p.first_x  = pdb_pkg::coord_type'(fx);
      p.first_y  = pdb_pkg::coord_type'(fy);
      p.second_x = pdb_pkg::coord_type'(sx);
      p.second_y = pdb_pkg::coord_type'(sy);
      // every third stretch of 120 requests goes back to back
      p.idle_before = ((pairs_made / 120) % 3 == 0) ? 4'd0 : 4'($urandom_range(0, 14));
      p.wait_drain  = drain;
      pair_queue.push_back(p);
      pairs_made++;
   endtask

   function automatic int corner_coord();
      int v;
      case ($urandom_range(0, 4))
         0:       v = -32768;
         1:       v = 32767;
         2:       v = 0;
         3:       v = -1;
         default: v = $urandom_range(0, 65535) - 32768;
      endcase
      return v;
   endfunction

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      req_ch.valid    = 1'b0;
      req_ch.first_x  = '0;
      req_ch.first_y  = '0;
      req_ch.second_x = '0;
      req_ch.second_y = '0;
      rsp_ch.ready    = 1'b0;
      fork
         forever #5 clock = ~clock;
      join_none
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
   end

   // request driver
   always @(negedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
         have_pair = 1'b0;
         idle_left = 0;
      end else if (!req_ch.valid || req_taken) begin
         if (!have_pair && pair_queue.size() != 0) begin
            cur_pair  = pair_queue.pop_front();
            have_pair = 1'b1;
            idle_left = cur_pair.idle_before;
         end
         if (have_pair && idle_left > 0) begin
            idle_left--;
            req_ch.valid <= 1'b0;
         end else if (have_pair && cur_pair.wait_drain && polar_expect.size() != 0) begin
            req_ch.valid <= 1'b0;
         end else if (have_pair) begin
            req_ch.first_x  <= cur_pair.first_x;
            req_ch.first_y  <= cur_pair.first_y;
            req_ch.second_x <= cur_pair.second_x;
            req_ch.second_y <= cur_pair.second_y;
            req_ch.valid    <= 1'b1;
            have_pair = 1'b0;
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   // response receiver with random back pressure and one long hold
   always @(negedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         rsp_seen  = 0;
         wait_left = 0;
         hold_left = 0;
      end else begin
         if (rsp_taken) begin
            rsp_seen++;
            wait_left = ((rsp_seen / 150) % 3 == 1) ? 0 : $urandom_range(0, 14);
            if (rsp_seen == RSP_HOLD_AT)
               hold_left = RSP_HOLD_LEN;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else if (wait_left > 0) begin
            wait_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   // monitor and checker
   always @(posedge clock) begin
      polar_type want;
      if (reset) begin
         req_taken <= 1'b0;
         rsp_taken <= 1'b0;
      end else begin
         req_taken <= req_ch.valid && req_ch.ready;
         rsp_taken <= rsp_ch.valid && rsp_ch.ready;
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (polar_expect.size() == 0) begin
               report_mismatch($sformatf("response with none pending: span %0d bearing %0d",
                                         rsp_ch.span, rsp_ch.bearing));
            end else begin
               want = polar_expect.pop_front();
               if (rsp_ch.span !== want.span)
                  report_mismatch($sformatf("span got %0d want %0d for (%0d,%0d)->(%0d,%0d)",
                                            rsp_ch.span, want.span, want.first_x,
                                            want.first_y, want.second_x, want.second_y));
               if (rsp_ch.bearing !== want.bearing)
                  report_mismatch($sformatf("bearing got %0d want %0d for (%0d,%0d)->(%0d,%0d)",
                                            rsp_ch.bearing, want.bearing, want.first_x,
                                            want.first_y, want.second_x, want.second_y));
            end
         end
         if (req_ch.valid && req_ch.ready)
            polar_expect.push_back(predict_polar(req_ch.first_x, req_ch.first_y,
                                                 req_ch.second_x, req_ch.second_y));
      end
   end

   // watchdog: ends the run when neither channel moves for too long
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      int fx, fy, sx, sy;
      fault_count = 0;
      pairs_made  = 0;

      // directed: coincident points, axes, quadrant turns, extreme differences
      push_pair(0, 0, 0, 0, 1'b0);
      push_pair(32767, -32768, 32767, -32768, 1'b0);
      push_pair(-32768, 32767, 32767, -32768, 1'b0);
      push_pair(32767, -32768, -32768, 32767, 1'b0);
      push_pair(32767, 32767, -32768, -32768, 1'b0);
      push_pair(-32768, -32768, 32767, 32767, 1'b0);
      push_pair(0, 0, 1, 0, 1'b0);
      push_pair(100, 0, -100, 0, 1'b0);        // straight left: wraps to -pi
      push_pair(32767, 0, -32768, 0, 1'b0);
      push_pair(0, 5, 0, 0, 1'b0);
      push_pair(0, -32768, 0, 32767, 1'b0);
      push_pair(0, 0, -1, -1, 1'b0);
      push_pair(0, 0, -1, 1, 1'b0);
      push_pair(-32768, 0, 0, 0, 1'b0);
      push_pair(0, 0, 16, -16, 1'b0);
      push_pair(1000, -2000, -3000, 4000, 1'b1);

      for (int n = 0; n < RANDOM_PAIRS; n++) begin
         fx = $urandom_range(0, 65535) - 32768;
         fy = $urandom_range(0, 65535) - 32768;
         sx = $urandom_range(0, 65535) - 32768;
         sy = $urandom_range(0, 65535) - 32768;
         case ($urandom_range(0, 9))
            4, 5, 6: begin
               sx = fx + $urandom_range(0, 128) - 64;
               sy = fy + $urandom_range(0, 128) - 64;
            end
            7: begin
               // coincident or on an axis
               case ($urandom_range(0, 2))
                  0: begin sx = fx; sy = fy; end
                  1: sy = fy;
                  default: sx = fx;
               endcase
            end
            8: begin
               fx = corner_coord();
               fy = corner_coord();
               sx = corner_coord();
               sy = corner_coord();
            end
            9: begin
               fx = $urandom_range(0, 32) - 16;
               fy = $urandom_range(0, 32) - 16;
               sx = $urandom_range(0, 32) - 16;
               sy = $urandom_range(0, 32) - 16;
            end
            default: ;
         endcase
         push_pair(fx, fy, sx, sy, (n == 600 || n == 1100));
      end

      wait (!reset);
      wait (pair_queue.size() == 0 && !have_pair && !req_ch.valid);
      wait (polar_expect.size() == 0);
      repeat (pdb_pkg::NUM_STAGES + 6) @(posedge clock);
      if (polar_expect.size() != 0)
         report_mismatch($sformatf("%0d responses never arrived", polar_expect.size()));
      if (fault_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
